FILE: hdl/radio_telegram_byte_parser_unit_defines.svh
// assertion macros shared by the parser rtl
`ifndef RADIO_TELEGRAM_BYTE_PARSER_UNIT_DEFINES_SVH
`define RADIO_TELEGRAM_BYTE_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define RTBP_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rtbp assertion failed");

// antecedent implies consequent in the next cycle
`define RTBP_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rtbp assertion failed");

`else

`define RTBP_ASSERT_IMP(lbl, clk, rst, pre, post)
`define RTBP_ASSERT_NXT(lbl, clk, rst, pre, post)

`endif

`endif

FILE: hdl/rtbp_pkg.sv
package rtbp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_BYTE      = 2'd0,
      CSR_TYPE_SWITCH    = 2'd1,
      CSR_TYPE_ONE_BYTE  = 2'd2,
      CSR_TYPE_FOUR_BYTE = 2'd3
   } rtbp_csr_index_type;

   localparam logic [BYTE_W-1:0] SYNC_BYTE_RST      = 8'h55;
   localparam logic [BYTE_W-1:0] TYPE_SWITCH_RST    = 8'hF6;
   localparam logic [BYTE_W-1:0] TYPE_ONE_BYTE_RST  = 8'hD5;
   localparam logic [BYTE_W-1:0] TYPE_FOUR_BYTE_RST = 8'hA5;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_byte;
      logic [BYTE_W-1:0] type_switch;
      logic [BYTE_W-1:0] type_one_byte;
      logic [BYTE_W-1:0] type_four_byte;
   } rtbp_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] radio_type;
      logic [WORD_W-1:0] sender_id;
      logic [WORD_W-1:0] data_word;
      logic [BYTE_W-1:0] signal_raw;
   } rtbp_result_type;

   // handshake between input stage and parse stage
   typedef struct packed {
      logic valid;
      logic advance;
   } rtbp_stage_ctl_type;

endpackage

FILE: hdl/rtbp_req_if.sv
interface rtbp_req_if
   import rtbp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/rtbp_rsp_if.sv
interface rtbp_rsp_if
   import rtbp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] radio_type;
   logic [WORD_W-1:0] sender_id;
   logic [WORD_W-1:0] data_word;
   logic [BYTE_W-1:0] signal_raw;

   modport source (output valid, output radio_type, output sender_id,
                   output data_word, output signal_raw, input ready);
   modport sink (input valid, input radio_type, input sender_id,
                 input data_word, input signal_raw, output ready);
endinterface

FILE: hdl/rtbp_csr.sv
module rtbp_csr
   import rtbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] index,
   input  logic [BYTE_W-1:0]      wdata,
   output rtbp_cfg_type           cfg
);

   rtbp_cfg_type cfg_ff;
   rtbp_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (rtbp_csr_index_type'(index))
            CSR_SYNC_BYTE:      cfg_in.sync_byte      = wdata;
            CSR_TYPE_SWITCH:    cfg_in.type_switch    = wdata;
            CSR_TYPE_ONE_BYTE:  cfg_in.type_one_byte  = wdata;
            CSR_TYPE_FOUR_BYTE: cfg_in.type_four_byte = wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte      <= SYNC_BYTE_RST;
         cfg_ff.type_switch    <= TYPE_SWITCH_RST;
         cfg_ff.type_one_byte  <= TYPE_ONE_BYTE_RST;
         cfg_ff.type_four_byte <= TYPE_FOUR_BYTE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/rtbp_in_reg.sv
module rtbp_in_reg
   import rtbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               src_valid,
   input  logic [BYTE_W-1:0]  src_byte,
   output logic               src_ready,
   input  logic               advance,
   output logic               held_valid,
   output logic [BYTE_W-1:0]  held_byte
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              take;

   // room when empty or when the held byte moves on this cycle
   assign src_ready = !valid_ff || advance;
   assign take      = src_valid && src_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= src_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

FILE: hdl/rtbp_walker.sv
`include "radio_telegram_byte_parser_unit_defines.svh"

module rtbp_walker
   import rtbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [BYTE_W-1:0]  rx_byte,
   input  rtbp_cfg_type       cfg,
   output logic               emit,
   output rtbp_result_type    result
);

   localparam logic [4:0] POS_HUNT   = 5'd0;
   localparam logic [4:0] POS_TYPE   = 5'd6;
   localparam logic [4:0] POS_DATA0  = 5'd7;
   localparam logic [4:0] POS_DATA1  = 5'd8;
   localparam logic [4:0] POS_DATA3  = 5'd10;
   localparam logic [4:0] POS_SEND0  = 5'd11;
   localparam logic [4:0] POS_SEND3  = 5'd14;
   localparam logic [4:0] POS_SIGNAL = 5'd21;
   localparam logic [4:0] POS_FINAL  = 5'd23;

   logic [4:0]        pos_ff;
   logic [4:0]        pos_in;
   logic [BYTE_W-1:0] type_ff;
   logic [BYTE_W-1:0] type_in;
   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic [WORD_W-1:0] sender_ff;
   logic [WORD_W-1:0] sender_in;
   logic [BYTE_W-1:0] signal_ff;
   logic [BYTE_W-1:0] signal_in;
   logic [1:0]        data_lane;
   logic [1:0]        send_lane;
   logic              type_short;
   logic              type_long;
   logic [4:0]        pos_next;

   // byte lane counted from the top byte
   assign data_lane  = 2'd3 - 2'(pos_ff - POS_DATA0);
   assign send_lane  = 2'd3 - 2'(pos_ff - POS_SEND0);
   assign type_short = (type_ff == cfg.type_one_byte) || (type_ff == cfg.type_switch);
   assign type_long  = (type_ff == cfg.type_four_byte);
   assign pos_next   = 5'(pos_ff + 5'd1);

   always_comb begin
      pos_in    = pos_ff;
      type_in   = type_ff;
      data_in   = data_ff;
      sender_in = sender_ff;
      signal_in = signal_ff;
      emit      = 1'b0;
      if (step) begin
         priority if (pos_ff == POS_HUNT || pos_ff > POS_FINAL) begin
            pos_in = (rx_byte == cfg.sync_byte) ? 5'd1 : POS_HUNT;
         end else if (pos_ff < POS_TYPE) begin
            pos_in = pos_next;
         end else if (pos_ff == POS_TYPE) begin
            type_in = rx_byte;
            pos_in  = POS_DATA0;
         end else if (pos_ff == POS_DATA0) begin
            data_in[WORD_W-1 -: BYTE_W] = rx_byte;
            priority if (type_short) begin
               pos_in = POS_SEND0;
            end else if (type_long) begin
               pos_in = POS_DATA1;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff <= POS_DATA3) begin
            data_in[{data_lane, 3'b000} +: BYTE_W] = rx_byte;
            pos_in = pos_next;
         end else if (pos_ff <= POS_SEND3) begin
            sender_in[{send_lane, 3'b000} +: BYTE_W] = rx_byte;
            pos_in = pos_next;
         end else if (pos_ff == POS_SIGNAL) begin
            signal_in = rx_byte;
            pos_in    = pos_next;
         end else if (pos_ff < POS_FINAL) begin
            pos_in = pos_next;
         end else begin
            emit      = 1'b1;
            data_in   = '0;
            sender_in = '0;
            signal_in = '0;
            pos_in    = POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HUNT;
         type_ff   <= '0;
         data_ff   <= '0;
         sender_ff <= '0;
         signal_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         type_ff   <= type_in;
         data_ff   <= data_in;
         sender_ff <= sender_in;
         signal_ff <= signal_in;
      end
   end

   assign result.radio_type = type_ff;
   assign result.sender_id  = sender_ff;
   assign result.data_word  = data_ff;
   assign result.signal_raw = signal_ff;

   `RTBP_ASSERT_NXT(a_final_clears, clock, reset, emit,
      pos_ff == POS_HUNT && data_ff == '0 && sender_ff == '0 && signal_ff == '0)
   `RTBP_ASSERT_NXT(a_hold_when_idle, clock, reset, !step,
      $stable(pos_ff) && $stable(data_ff) && $stable(sender_ff))
   `RTBP_ASSERT_NXT(a_unknown_type_drops, clock, reset,
      step && pos_ff == POS_DATA0 && !type_short && !type_long, pos_ff == POS_HUNT)

endmodule

FILE: hdl/rtbp_out_reg.sv
module rtbp_out_reg
   import rtbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rtbp_result_type load_data,
   input  logic            sink_ready,
   output logic            out_valid,
   output rtbp_result_type out_data
);

   logic            valid_ff;
   logic            valid_in;
   rtbp_result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (sink_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/radio_telegram_byte_parser_unit.sv
// radio telegram byte parser: takes one received serial byte per req transfer and
// walks a fixed-layout frame (sync, four header bytes, header check, type, one or
// four data bytes, four sender bytes, status, count, four destination bytes,
// signal, security level, final check). on the final byte one rsp transfer carries
// type, sender id, data word and raw signal strength. each byte is held in
// the input register and is parsed on its way into the result register, so
// rsp_bus.valid rises once the final byte has passed the input register and its
// result is in the result register; with rsp_bus.ready held high the block
// takes one byte every cycle. while a result waits unread the parse stage holds,
// the input register takes at most one more byte and req_bus.ready then stays low
// until the result is taken. csr writes take effect on the next cycle and should
// be issued while no byte is in flight.
module radio_telegram_byte_parser_unit
   import rtbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rtbp_req_if.sink               req_bus,
   rtbp_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata
);

   rtbp_cfg_type       cfg;
   rtbp_stage_ctl_type stage;
   logic [BYTE_W-1:0]  held_byte;
   logic               emit;
   rtbp_result_type    walk_result;
   rtbp_result_type    out_data;
   logic               out_valid;

   // register file for sync and type codes
   rtbp_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   // parse stage moves whenever it holds a byte and the output register has room
   assign stage.advance = stage.valid && (!out_valid || rsp_bus.ready);

   // input register
   rtbp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .src_valid  (req_bus.valid),
      .src_byte   (req_bus.rx_byte),
      .src_ready  (req_bus.ready),
      .advance    (stage.advance),
      .held_valid (stage.valid),
      .held_byte  (held_byte)
   );

   // frame position and captured fields
   rtbp_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .step    (stage.advance),
      .rx_byte (held_byte),
      .cfg     (cfg),
      .emit    (emit),
      .result  (walk_result)
   );

   // result register
   rtbp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .load_data  (walk_result),
      .sink_ready (rsp_bus.ready),
      .out_valid  (out_valid),
      .out_data   (out_data)
   );

   assign rsp_bus.valid      = out_valid;
   assign rsp_bus.radio_type = out_data.radio_type;
   assign rsp_bus.sender_id  = out_data.sender_id;
   assign rsp_bus.data_word  = out_data.data_word;
   assign rsp_bus.signal_raw = out_data.signal_raw;

endmodule
